// ----- src/rvhz_pkg.sv -----
package rvhz_pkg;

   localparam logic [31:0] NOP_WORD = 32'h0000_0033;

   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_FENCE  = 7'b0001111;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;

   typedef enum logic [2:0] {
      CLS_U   = 3'd0,
      CLS_J   = 3'd1,
      CLS_B   = 3'd2,
      CLS_IAR = 3'd3,
      CLS_ILO = 3'd4,
      CLS_R   = 3'd5,
      CLS_S   = 3'd6,
      CLS_UNK = 3'd7
   } instr_class_type;

   typedef struct packed {
      logic            stall;
      instr_class_type cls;
      logic [4:0]      dest;
   } check_type;

   function automatic instr_class_type classify(input logic [6:0] op);
      instr_class_type cls;
      case (op) inside
         OP_LUI, OP_AUIPC:                     cls = CLS_U;
         OP_JAL:                               cls = CLS_J;
         OP_BRANCH:                            cls = CLS_B;
         OP_JALR, OP_IMM, OP_FENCE, OP_SYSTEM: cls = CLS_IAR;
         OP_LOAD:                              cls = CLS_ILO;
         OP_REG:                               cls = CLS_R;
         OP_STORE:                             cls = CLS_S;
         default:                              cls = CLS_UNK;
      endcase
      return cls;
   endfunction

endpackage

// ----- src/rvhz_hazard_check.sv -----
module rvhz_hazard_check (
   input  logic [31:0]         instr_word,
   input  logic [4:0]          dest_prev_one,
   input  logic [4:0]          dest_prev_two,
   output rvhz_pkg::check_type chk
);
   import rvhz_pkg::*;

   instr_class_type cls;
   logic [4:0]      rs1;
   logic [4:0]      rs2;
   logic            chk1;
   logic            chk2;
   logic            is_nop;
   logic            hit_one;
   logic            hit_two;

   assign cls    = classify(instr_word[6:0]);
   assign rs1    = instr_word[19:15];
   assign rs2    = instr_word[24:20];
   assign is_nop = (instr_word == NOP_WORD);

   always_comb begin
      chk1 = 1'b0;
      chk2 = 1'b0;
      case (cls) inside
         CLS_R, CLS_S, CLS_B: begin
            chk1 = 1'b1;
            chk2 = 1'b1;
         end
         CLS_IAR, CLS_ILO: chk1 = 1'b1;
         default: ;
      endcase
   end

   assign hit_one = (dest_prev_one != 5'd0) &&
                    ((chk1 && dest_prev_one == rs1) || (chk2 && dest_prev_one == rs2));
   assign hit_two = (dest_prev_two != 5'd0) &&
                    ((chk1 && dest_prev_two == rs1) || (chk2 && dest_prev_two == rs2));

   // A hit on either older word stalls; each emitted NOP shifts the history,
   // so re-checking every cycle yields two NOPs for the last word, one for the older.
   assign chk.stall = !is_nop && (hit_one || hit_two);
   assign chk.cls   = cls;
   assign chk.dest  = (cls == CLS_S || cls == CLS_B || is_nop) ? 5'd0 : instr_word[11:7];

endmodule

// ----- src/riscv_raw_hazard_nop_inserter_core.sv -----
// Read-after-write hazard NOP inserter for an RV32I instruction stream. Each
// input beat is one instruction; each output beat is either an inserted NOP
// (add x0,x0,x0) or the instruction itself, which closes its run with tlast.
// The instruction is checked against the destinations of the last two words sent:
// a hit on the last one puts two NOPs ahead of it, a hit only on the one
// before puts one. The block takes one instruction per cycle when no hazard
// exists and the output is not stalled; while NOPs go out the instruction waits
// in the single hold slot in front of the output register, and no new one is taken.
// Each instruction passes the hold register and then the output register.
module riscv_raw_hazard_nop_inserter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_word
   output logic [3:0]  rsp_tuser,   // [0] is_inserted, [3:1] instr_class
   output logic        rsp_tlast    // last_of_run
);
   import rvhz_pkg::*;

   logic            hold_valid_ff;
   logic            hold_valid_in;
   logic [31:0]     hold_word_ff;
   logic [4:0]      dest_prev_one_ff;
   logic [4:0]      dest_prev_one_in;
   logic [4:0]      dest_prev_two_ff;
   logic [4:0]      dest_prev_two_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic [31:0]     out_word_ff;
   logic            out_inserted_ff;
   instr_class_type out_class_ff;
   logic            out_last_ff;
   check_type       chk;
   logic            emit;
   logic            req_take;

   rvhz_hazard_check u_check (
      .instr_word    (hold_word_ff),
      .dest_prev_one (dest_prev_one_ff),
      .dest_prev_two (dest_prev_two_ff),
      .chk           (chk)
   );

   assign emit       = hold_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || (emit && !chk.stall);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in    = hold_valid_ff;
      dest_prev_one_in = dest_prev_one_ff;
      dest_prev_two_in = dest_prev_two_ff;
      out_valid_in     = out_valid_ff && !rsp_tready;
      if (emit) begin
         out_valid_in     = 1'b1;
         dest_prev_two_in = dest_prev_one_ff;
         dest_prev_one_in = chk.stall ? 5'd0 : chk.dest;
         if (!chk.stall) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff    <= 1'b0;
         dest_prev_one_ff <= 5'd0;
         dest_prev_two_ff <= 5'd0;
         out_valid_ff     <= 1'b0;
      end else begin
         hold_valid_ff    <= hold_valid_in;
         dest_prev_one_ff <= dest_prev_one_in;
         dest_prev_two_ff <= dest_prev_two_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_word_ff <= req_tdata;
      end
      if (emit) begin
         out_word_ff     <= chk.stall ? NOP_WORD : hold_word_ff;
         out_inserted_ff <= chk.stall;
         out_class_ff    <= chk.stall ? CLS_R : chk.cls;
         out_last_ff     <= !chk.stall;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = {out_class_ff, out_inserted_ff};
   assign rsp_tlast  = out_last_ff;

   // inserted NOP beats carry the NOP word and never close a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == NOP_WORD && !rsp_tlast)
      else $error("inserted beat malformed");

   // an emitted NOP clears the newest destination
   assert property (@(posedge clock) disable iff (reset)
      emit && chk.stall |=> dest_prev_one_ff == 5'd0)
      else $error("NOP did not clear destination history");

   // never take a new instruction while the held one still stalls
   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && chk.stall |-> !req_tready)
      else $error("input taken during stall");

   // a held instruction with a free output slot puts a beat, itself or a NOP, into the output register
   assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid_ff)
      else $error("emitted beat lost");

endmodule
